FILE: src/cmac_pkg.sv
// ----------------------------------------------------------------------------
// cmac_pkg
// Shared types, constants and AES round functions for the CMAC engine.
// ----------------------------------------------------------------------------
package cmac_pkg;

  typedef logic [127:0] blk_t;
  typedef blk_t [10:0] rkeys_t;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockBytes = 16;
  localparam logic [7:0] CmacRb = 8'h87;
  localparam logic [7:0] CmacPad = 8'h80;

  localparam logic [0:255][7:0] Sbox = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  typedef struct packed {
    logic ready;
    logic lgen;
  } ks_stat_t;

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  // sub bytes and shift rows; byte 0 sits in the top bits
  function automatic blk_t sub_shift(blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8 * (c * 4 + i) -: 8] = Sbox[s[127 - 8 * (((c + i) % 4) * 4 + i) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_cols(blk_t t);
    blk_t s;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = t[127 - 32 * c -: 8];
      a1 = t[119 - 32 * c -: 8];
      a2 = t[111 - 32 * c -: 8];
      a3 = t[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      s[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      s[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      s[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      s[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return s;
  endfunction

  function automatic blk_t gf_double(blk_t a);
    return {a[126:0], 1'b0} ^ (a[127] ? {120'd0, CmacRb} : 128'd0);
  endfunction

endpackage

FILE: src/cmac_in_if.sv
// ----------------------------------------------------------------------------
// cmac_in_if
// Message block channel: valid/ready handshake with one 16-byte block.
// ----------------------------------------------------------------------------
interface cmac_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic [4:0]  valid_bytes;
  logic        final_block;

  modport source (output valid, data_high, data_low, valid_bytes, final_block,
                  input ready);
  modport sink (input valid, data_high, data_low, valid_bytes, final_block,
                output ready);
endinterface

FILE: src/cmac_out_if.sv
// ----------------------------------------------------------------------------
// cmac_out_if
// Tag channel: valid/ready handshake with one 128-bit tag.
// ----------------------------------------------------------------------------
interface cmac_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_high;
  logic [63:0] tag_low;

  modport source (output valid, tag_high, tag_low, input ready);
  modport sink (input valid, tag_high, tag_low, output ready);
endinterface

FILE: src/cmac_aes_core.sv
// ----------------------------------------------------------------------------
// cmac_aes_core
// Unrolled AES-128 encryption of one block with precomputed round keys.
// ----------------------------------------------------------------------------
module cmac_aes_core import cmac_pkg::*; (
  input  rkeys_t rk,
  input  blk_t   din,
  output blk_t   dout
);

  blk_t st [NumRounds + 1];

  assign st[0] = din ^ rk[0];

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    if (r < NumRounds) begin : g_full
      assign st[r] = mix_cols(sub_shift(st[r - 1])) ^ rk[r];
    end else begin : g_last
      assign st[r] = sub_shift(st[r - 1]) ^ rk[r];
    end
  end

  assign dout = st[NumRounds];

endmodule

FILE: src/cmac_key_sched.sv
// ----------------------------------------------------------------------------
// cmac_key_sched
// Key registers, round key expansion (one round a cycle) and subkey setup.
// ----------------------------------------------------------------------------
module cmac_key_sched import cmac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_data,
  input  blk_t        aes_out,
  output rkeys_t      rk,
  output blk_t        k1,
  output blk_t        k2,
  output ks_stat_t    stat
);

  typedef enum logic [1:0] {EXPAND, LGEN, DONE} ks_state_t;

  ks_state_t   state_r;
  logic [3:0]  cnt_r;
  logic [63:0] key_hi_r, key_lo_r;
  blk_t        rk_r [1:NumRounds];
  blk_t        prev, nxt_rk, k1_r, k2_r;
  logic [31:0] tw;
  logic [7:0]  rcon;

  always_comb begin
    case (cnt_r)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  end

  always_comb begin
    // round key r is built from round key r-1
    prev = (cnt_r == 4'd1) ? {key_hi_r, key_lo_r} : rk_r[cnt_r - 4'd1];
    tw = sub_word({prev[23:0], prev[31:24]}) ^ {rcon, 24'd0};
    nxt_rk[127:96] = prev[127:96] ^ tw;
    nxt_rk[95:64]  = prev[95:64] ^ nxt_rk[127:96];
    nxt_rk[63:32]  = prev[63:32] ^ nxt_rk[95:64];
    nxt_rk[31:0]   = prev[31:0] ^ nxt_rk[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= EXPAND;
      cnt_r    <= 4'd1;
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      state_r <= EXPAND;
      cnt_r   <= 4'd1;
      if (cfg_idx) begin
        key_lo_r <= cfg_data;
      end else begin
        key_hi_r <= cfg_data;
      end
    end else begin
      case (state_r)
        EXPAND: begin
          if (cnt_r == 4'(NumRounds)) begin
            state_r <= LGEN;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        LGEN:    state_r <= DONE;
        default: state_r <= state_r;
      endcase
    end
  end

  // round key store; entry r is written while the expand counter equals r
  always_ff @(posedge clk) begin
    if (state_r == EXPAND && !cfg_we) begin
      for (int r = 1; r <= NumRounds; r++) begin
        if (cnt_r == 4'(r)) rk_r[r] <= nxt_rk;
      end
    end
    if (state_r == LGEN && !cfg_we) begin
      k1_r <= gf_double(aes_out);
      k2_r <= gf_double(gf_double(aes_out));
    end
  end

  always_comb begin
    rk[0] = {key_hi_r, key_lo_r};
    for (int r = 1; r <= NumRounds; r++) rk[r] = rk_r[r];
  end

  assign k1 = k1_r;
  assign k2 = k2_r;
  assign stat.ready = (state_r == DONE);
  assign stat.lgen  = (state_r == LGEN);

endmodule

FILE: src/aes128_cmac_engine_core.sv
// ----------------------------------------------------------------------------
// aes128_cmac_engine_core
// AES-128 CMAC engine, one message block per cycle unless key setup or a held tag stalls it.
// ----------------------------------------------------------------------------
// The key is written through cfg_we/cfg_idx/cfg_data (index 0 upper half,
// index 1 lower half). After reset or any key write, the round keys are
// expanded one per cycle and the zero block is encrypted to derive K1/K2,
// while in_ch.ready stays low.
// Blocks arrive on in_ch. A block is padded and masked on transfer into the
// input register; from there one unrolled AES pass updates the chain, so a
// block is accepted every cycle, bounded by the chain feedback through the
// AES datapath, while the subkeys are ready and no final block waits. On the
// final block the tag goes to the output register and the chain clears to zero.
// If out_ch stalls with a tag held, one more block may sit in the input
// register; a final one waits there, non-final ones keep flowing.
// Reset clears the chain, the pipeline valids and the key to zero.
// ----------------------------------------------------------------------------
module aes128_cmac_engine_core import cmac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_data,
  cmac_in_if.sink     in_ch,
  cmac_out_if.source  out_ch
);

  rkeys_t   rk;
  blk_t     k1, k2, aes_in, aes_out, blk_in;
  ks_stat_t ks;

  logic s1_vld_r, s1_final_r, out_vld_r, s1_go, in_xfer;
  blk_t s1_blk_r, chain_r, tag_r;
  logic [4:0] nbytes;

  cmac_key_sched u_ks (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .aes_out, .rk, .k1, .k2, .stat(ks)
  );

  cmac_aes_core u_aes (.rk, .din(aes_in), .dout(aes_out));

  assign aes_in = ks.lgen ? '0 : (chain_r ^ s1_blk_r);

  assign s1_go       = s1_vld_r && (!s1_final_r || !out_vld_r || out_ch.ready);
  assign in_ch.ready = ks.ready && (!s1_vld_r || s1_go);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // pad and mask the block on the way in
  always_comb begin
    blk_t raw;
    raw    = {in_ch.data_high, in_ch.data_low};
    nbytes = (in_ch.valid_bytes > 5'(BlockBytes)) ? 5'(BlockBytes) : in_ch.valid_bytes;
    if (!in_ch.final_block) begin
      blk_in = raw;
    end else if (nbytes == 5'(BlockBytes)) begin
      blk_in = raw ^ k1;
    end else begin
      for (int k = 0; k < BlockBytes; k++) begin
        if (5'(k) < nbytes) blk_in[127 - 8 * k -: 8] = raw[127 - 8 * k -: 8];
        else if (5'(k) == nbytes) blk_in[127 - 8 * k -: 8] = CmacPad;
        else blk_in[127 - 8 * k -: 8] = 8'h00;
      end
      blk_in = blk_in ^ k2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      chain_r   <= '0;
    end else begin
      if (in_xfer) s1_vld_r <= 1'b1;
      else if (s1_go) s1_vld_r <= 1'b0;
      if (s1_go) chain_r <= s1_final_r ? '0 : aes_out;
      if (s1_go && s1_final_r) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_blk_r   <= blk_in;
      s1_final_r <= in_ch.final_block;
    end
    if (s1_go && s1_final_r) tag_r <= aes_out;
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.tag_high = tag_r[127:64];
  assign out_ch.tag_low  = tag_r[63:0];

  a_ready_keys : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> ks.ready) else $error("transfer while subkeys not ready");

  a_chain_clr : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_final_r) |=> (chain_r == '0)) else $error("chain not cleared");

  a_key_wr : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready) else $error("ready right after key write");

  a_no_loss : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> out_vld_r) else $error("tag dropped");

endmodule

FILE: test/cmac_tag_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmac_tag_checker
// Watches the key port, the block channel and the tag channel of the CMAC engine, keeps its
// own AES-128 CMAC chain and subkeys, and compares every tag transfer with
// the oldest predicted tag.
// ----------------------------------------------------------------------------
module cmac_tag_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_data,
  cmac_in_if          in_mon,
  cmac_out_if         out_mon,
  output int          error_count,
  output int          tags_pending,
  output int          blocks_seen,
  output int          tags_seen
);

  localparam logic [0:255][7:0] SubTab = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  localparam logic [0:9][7:0] RoundConst = {
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };
  localparam logic [7:0]  ReduceByte = 8'h87;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam int unsigned FullBytes  = 16;

  logic [127:0] key_q;
  logic [127:0] chain_q;
  logic [127:0] sub_k1;
  logic [127:0] sub_k2;
  logic [127:0] sched [0:10];
  logic [127:0] tag_fifo [$];

  function automatic logic [7:0] times_two(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] gf_times_two(logic [127:0] a);
    return {a[126:0], 1'b0} ^ (a[127] ? {120'd0, ReduceByte} : 128'd0);
  endfunction

  function automatic logic [127:0] aes_encrypt_block(logic [127:0] blk);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, al;
    logic [127:0] x;
    x = blk ^ sched[0];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = SubTab[x[127 - 8 * i -: 8]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[c * 4 + i] = s[((c + i) % 4) * 4 + i];
      for (int c = 0; c < 4; c++) begin
        a0 = t[c * 4];
        a1 = t[c * 4 + 1];
        a2 = t[c * 4 + 2];
        a3 = t[c * 4 + 3];
        al = a0 ^ a1 ^ a2 ^ a3;
        if (r != 10) begin
          s[c * 4]     = a0 ^ al ^ times_two(a0 ^ a1);
          s[c * 4 + 1] = a1 ^ al ^ times_two(a1 ^ a2);
          s[c * 4 + 2] = a2 ^ al ^ times_two(a2 ^ a3);
          s[c * 4 + 3] = a3 ^ al ^ times_two(a3 ^ a0);
        end else begin
          for (int i = 0; i < 4; i++) s[c * 4 + i] = t[c * 4 + i];
        end
      end
      for (int i = 0; i < 16; i++) x[127 - 8 * i -: 8] = s[i];
      x = x ^ sched[r];
    end
    return x;
  endfunction

  // expand the key and derive both subkeys from the encrypted zero block
  function automatic void derive_subkeys();
    logic [31:0] w [44];
    logic [31:0] tmp;
    for (int i = 0; i < 4; i++) w[i] = key_q[127 - 32 * i -: 32];
    for (int i = 4; i < 44; i++) begin
      tmp = w[i - 1];
      if (i % 4 == 0) begin
        tmp = {tmp[23:0], tmp[31:24]};
        tmp = {SubTab[tmp[31:24]], SubTab[tmp[23:16]], SubTab[tmp[15:8]], SubTab[tmp[7:0]]}
              ^ {RoundConst[i / 4 - 1], 24'd0};
      end
      w[i] = w[i - 4] ^ tmp;
    end
    for (int r = 0; r < 11; r++) sched[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    sub_k1 = gf_times_two(aes_encrypt_block(128'd0));
    sub_k2 = gf_times_two(sub_k1);
  endfunction

  function automatic logic [127:0] last_block_input(logic [127:0] blk, logic [4:0] vb);
    int unsigned  n;
    logic [127:0] keep;
    n = (vb > FullBytes) ? FullBytes : vb;
    if (n == FullBytes) return blk ^ sub_k1;
    keep = (n == 0) ? 128'd0 : ~128'd0 << (128 - 8 * n);
    return ((blk & keep) | ({120'd0, PadByte} << (120 - 8 * n))) ^ sub_k2;
  endfunction

  always @(posedge clk) begin
    logic [127:0] blk;
    logic [127:0] want;
    if (!rst_n) begin
      key_q   = '0;
      chain_q = '0;
      tag_fifo.delete();
      derive_subkeys();
      error_count <= 0;
      blocks_seen <= 0;
      tags_seen   <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx) key_q[63:0] = cfg_data;
        else key_q[127:64] = cfg_data;
        derive_subkeys();
      end
      if (out_mon.valid && out_mon.ready) begin
        tags_seen <= tags_seen + 1;
        if (tag_fifo.size() == 0) begin
          if (error_count < 10)
            $display("tag transfer with nothing pending: %h_%h",
                     out_mon.tag_high, out_mon.tag_low);
          error_count <= error_count + 1;
        end else begin
          want = tag_fifo.pop_front();
          if (out_mon.tag_high !== want[127:64] || out_mon.tag_low !== want[63:0]) begin
            if (error_count < 10)
              $display("tag mismatch: exp %h_%h got %h_%h", want[127:64], want[63:0],
                       out_mon.tag_high, out_mon.tag_low);
            error_count <= error_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        blocks_seen <= blocks_seen + 1;
        blk = {in_mon.data_high, in_mon.data_low};
        if (!in_mon.final_block) begin
          chain_q = aes_encrypt_block(chain_q ^ blk);
        end else begin
          tag_fifo.push_back(aes_encrypt_block(chain_q ^ last_block_input(blk,
                                               in_mon.valid_bytes)));
          chain_q = '0;
        end
      end
    end
    tags_pending = tag_fifo.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives key writes and message blocks into the CMAC engine under several
// idle and stall patterns, including a long output hold-off; the tag checker
// beside the engine predicts and compares every tag.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WatchLimit  = 4000;
  localparam int SettleWait  = 20;
  localparam int HoldCycles  = 300;
  localparam int PhaseBlocks = 470;
  localparam logic IdxUpper  = 1'b0;
  localparam logic IdxLower  = 1'b1;

  typedef enum int { IdleNone, IdleSend, IdleRecv, IdleBoth } idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [63:0] cfg_data;

  idle_mode_t idle_mode;
  bit         hold_req;
  int         sent;
  int         idle_cycles;
  int         error_count, tags_pending, blocks_seen, tags_seen;

  cmac_in_if  in_ch ();
  cmac_out_if out_ch ();

  aes128_cmac_engine_core u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  cmac_tag_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_mon(in_ch), .out_mon(out_ch), .error_count(error_count),
    .tags_pending(tags_pending), .blocks_seen(blocks_seen), .tags_seen(tags_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // tag receiver, with an optional long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= !((idle_mode == IdleRecv || idle_mode == IdleBoth)
                          && $urandom_range(99) < 69);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic [4:0] vb, logic fin);
    if ((idle_mode == IdleSend || idle_mode == IdleBoth) && $urandom_range(99) < 69) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 69) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_high   <= hi;
    in_ch.data_low    <= lo;
    in_ch.valid_bytes <= vb;
    in_ch.final_block <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // only while idle: every tag back and the pipeline drained
  task automatic write_key(logic idx, logic [63:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tags_pending != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_message();
    int          nblk;
    int          r;
    logic [4:0]  vb;
    nblk = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
    for (int i = 0; i < nblk; i++)
      send_block(rand_word(), rand_word(), 5'($urandom_range(31)), 1'b0);
    r = $urandom_range(99);
    if (r < 45) vb = 5'd16;
    else if (r < 85) vb = 5'($urandom_range(15));
    else vb = 5'($urandom_range(17, 31));
    send_block(rand_word(), rand_word(), vb, 1'b1);
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= IdxUpper;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data_high   <= '0;
    in_ch.data_low    <= '0;
    in_ch.valid_bytes <= '0;
    in_ch.final_block <= 1'b0;
    idle_mode = IdleNone;
    hold_req  = 1'b0;
    sent      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key of zero first
    send_block('0, '0, 5'd0, 1'b1);
    write_key(IdxUpper, 64'h2b7e151628aed2a6);
    write_key(IdxLower, 64'habf7158809cf4f3c);
    // empty message, full single block, short blocks of odd byte counts and one of eight
    send_block('1, '1, 5'd0, 1'b1);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
    for (int n = 1; n <= 15; n += 2)
      send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'(n), 1'b1);
    send_block('1, '1, 5'd8, 1'b1);
    // counts above sixteen, non-final counts ignored, empty after blocks
    send_block('1, '0, 5'd17, 1'b1);
    send_block('0, '1, 5'd31, 1'b1);
    send_block(64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef, 5'd3, 1'b0);
    send_block('1, '1, 5'd0, 1'b0);
    send_block('1, '1, 5'd0, 1'b1);
    send_block('0, '0, 5'd16, 1'b0);
    send_block('1, '1, 5'd16, 1'b1);

    // fill up behind a stalled receiver
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++)
      send_block(rand_word(), rand_word(), 5'($urandom_range(31)), 1'($urandom_range(1)));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_key(IdxUpper, '1);
          write_key(IdxLower, '1);
        end
        2: begin
          write_key(IdxUpper, '0);
          write_key(IdxLower, '0);
        end
        default: begin
          write_key(IdxUpper, {$urandom, $urandom});
          write_key(IdxLower, {$urandom, $urandom});
        end
      endcase
      idle_mode = idle_mode_t'(ph);
      while (sent < (ph + 1) * PhaseBlocks) begin
        random_message();
        // a message that straddles a key change
        if ($urandom_range(199) == 0) begin
          send_block(rand_word(), rand_word(), 5'd16, 1'b0);
          write_key(1'($urandom_range(1)), {$urandom, $urandom});
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (tags_pending != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
    $display("covered %0d blocks and %0d tags over four idle patterns and several keys",
             blocks_seen, tags_seen);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", error_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
